@@ rtl/core/imufd_pkg.sv @@
// shared constants, types and scaling functions of the imu frame decoder
package imufd_pkg;

    // frame layout
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam int unsigned IDX_W       = 4;
    localparam int unsigned STORE_DEPTH = 9;
    // position of the checksum byte, the eleventh byte of a frame
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(10);

    // field widths
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned AXIS_W  = 20;
    localparam int unsigned TEMP_W  = 17;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned TDATA_W = 80;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } packet_kind_t;

    // temperature: floor((raw*64 + 788800) / 85)
    // biased by 85*15393 so the numerator stays positive and below 2^22,
    // then divided by 85 with a reciprocal multiply (2^32 = 1 mod 85, exact)
    localparam int unsigned TEMP_NUM_W  = 22;
    localparam int unsigned TEMP_RCP_W  = 26;
    localparam int unsigned TEMP_SHIFT  = 32;
    localparam int unsigned TEMP_Q_W    = 16;
    localparam logic [TEMP_NUM_W:0]   TEMP_BIAS     = 23'd2097205;
    localparam logic [TEMP_RCP_W-1:0] TEMP_RECIP    = 26'd50529028;
    localparam logic [TEMP_W-1:0]     TEMP_Q_OFFSET = 17'd15393;

    // axis scaling, floor rounding through arithmetic shifts
    function automatic logic signed [AXIS_W-1:0] scale_axis(
        input packet_kind_t        kind,
        input logic [RAW_W-1:0]    raw
    );
        logic signed [23:0] raw_ext;
        logic signed [23:0] scaled;
        raw_ext = signed'({{8{raw[RAW_W-1]}}, raw});
        case (kind)
            KIND_ACCEL: scaled = raw_ext >>> 3;
            KIND_RATE:  scaled = (raw_ext * 24'sd125) >>> 3;
            KIND_ANGLE: scaled = (raw_ext * 24'sd45) >>> 5;
            default:    scaled = '0;
        endcase
        return scaled[AXIS_W-1:0];
    endfunction

    function automatic logic signed [TEMP_W-1:0] scale_temp(
        input logic [RAW_W-1:0] raw
    );
        logic [TEMP_NUM_W:0]                    num_ext;
        logic [TEMP_NUM_W+TEMP_RCP_W-1:0]       prod;
        logic [TEMP_Q_W-1:0]                    quot;
        logic [TEMP_W-1:0]                      diff;
        num_ext = {{1{raw[RAW_W-1]}}, raw, 6'd0} + TEMP_BIAS;
        prod    = {{TEMP_RCP_W{1'b0}}, num_ext[TEMP_NUM_W-1:0]}
                  * {{TEMP_NUM_W{1'b0}}, TEMP_RECIP};
        quot    = prod[TEMP_SHIFT +: TEMP_Q_W];
        diff    = {1'b0, quot} - TEMP_Q_OFFSET;
        return signed'(diff);
    endfunction

endpackage

@@ rtl/core/imu_uart_frame_decoder.sv @@
// imu serial frame decoder: 11-byte frames in, scaled axis and temperature items out
//
// input channel s_axis carries one received uart byte per item in s_axis_tdata
// while waiting for a frame every byte but 0x55 is dropped; a 0x55 opens an
// 11-byte frame (header, type, x/y/z and temperature as little-endian words,
// checksum). the checksum byte closes the frame and is not checked
// output channel m_axis carries one item per frame of known type (0x51 accel,
// 0x52 angular rate, 0x53 angle); unknown types close the frame silently
// all values are signed fixed point with 8 fraction bits, floor rounded
// the result is registered and valid in the cycle after the checksum byte is accepted
// throughput: one byte per cycle, but for a checksum byte held off (see stall);
// decode is one pass of constant multiplies from the frame registers into the output register
// stall: while a result waits in the output register, bytes keep flowing in;
// only the checksum byte of the next frame is held off until the result leaves
// reset: clears the byte position and the output valid, the frame bytes are
// left as they are and always rewritten before use
module imu_uart_frame_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // axis_x[19:0], axis_y[39:20], axis_z[59:40], temperature_c[76:60], zero fill
    output logic [imufd_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [imufd_pkg::KIND_W-1:0]       m_axis_tuser    // packet_kind
);

    localparam int unsigned AW = imufd_pkg::AXIS_W;
    localparam int unsigned TW = imufd_pkg::TEMP_W;

    // frame position and frame bytes (type byte plus eight data bytes)
    logic [imufd_pkg::IDX_W-1:0] byte_index_reg;
    logic [imufd_pkg::IDX_W-1:0] byte_index_next;
    logic [7:0]                  frame_store_reg [imufd_pkg::STORE_DEPTH];

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    imufd_pkg::packet_kind_t     out_kind_reg;
    logic signed [AW-1:0]        out_x_reg;
    logic signed [AW-1:0]        out_y_reg;
    logic signed [AW-1:0]        out_z_reg;
    logic signed [TW-1:0]        out_temp_reg;

    logic                        in_fire;
    logic                        at_last;
    logic                        store_we;
    logic [imufd_pkg::IDX_W-1:0] store_addr;
    logic                        frame_done;
    logic                        kind_known;
    imufd_pkg::packet_kind_t     kind;
    logic                        load_out;

    // the checksum byte needs a free output register, other bytes never wait
    assign at_last       = (byte_index_reg == imufd_pkg::LAST_INDEX);
    assign s_axis_tready = !at_last || !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // frame position tracking
    always_comb
    begin
        byte_index_next = byte_index_reg;
        store_we        = 1'b0;
        frame_done      = 1'b0;
        store_addr      = byte_index_reg - imufd_pkg::IDX_W'(1);
        if (in_fire)
        begin
            if (byte_index_reg == '0 || byte_index_reg > imufd_pkg::LAST_INDEX)
            begin
                // waiting for a header; out-of-range positions act the same
                byte_index_next = (s_axis_tdata == imufd_pkg::HEADER_BYTE) ?
                                  imufd_pkg::IDX_W'(1) : '0;
            end
            else if (!at_last)
            begin
                // type and data bytes; a 0x55 here is plain data
                store_we        = 1'b1;
                byte_index_next = byte_index_reg + imufd_pkg::IDX_W'(1);
            end
            else
            begin
                // checksum byte, ignored, closes the frame
                frame_done      = 1'b1;
                byte_index_next = '0;
            end
        end
    end

    // type byte decode
    always_comb
    begin
        kind_known = 1'b1;
        case (frame_store_reg[0])
            imufd_pkg::TYPE_ACCEL: kind = imufd_pkg::KIND_ACCEL;
            imufd_pkg::TYPE_RATE:  kind = imufd_pkg::KIND_RATE;
            imufd_pkg::TYPE_ANGLE: kind = imufd_pkg::KIND_ANGLE;
            default:
            begin
                kind       = imufd_pkg::KIND_ACCEL;
                kind_known = 1'b0;
            end
        endcase
    end

    assign load_out = frame_done && kind_known;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // frame bytes, no reset: each is written before the frame is decoded
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            frame_store_reg[store_addr] <= s_axis_tdata;
        end
    end

    // scaling straight from the frame registers into the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg <= kind;
            out_x_reg    <= imufd_pkg::scale_axis(kind,
                                {frame_store_reg[2], frame_store_reg[1]});
            out_y_reg    <= imufd_pkg::scale_axis(kind,
                                {frame_store_reg[4], frame_store_reg[3]});
            out_z_reg    <= imufd_pkg::scale_axis(kind,
                                {frame_store_reg[6], frame_store_reg[5]});
            out_temp_reg <= imufd_pkg::scale_temp(
                                {frame_store_reg[8], frame_store_reg[7]});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(imufd_pkg::TDATA_W - 3*AW - TW){1'b0}},
                            out_temp_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

@@ tb/sv/imu_uart_frame_decoder_test.sv @@
// testbench for the imu uart frame decoder: byte stream in, decoded samples checked out
`timescale 1ns / 1ps

module imu_uart_frame_decoder_test;

    // one decoded sample as it travels on the result channel
    typedef struct packed {
        imufd_pkg::packet_kind_t         kind;
        logic [imufd_pkg::AXIS_W-1:0]    ax;
        logic [imufd_pkg::AXIS_W-1:0]    ay;
        logic [imufd_pkg::AXIS_W-1:0]    az;
        logic [imufd_pkg::TEMP_W-1:0]    temp;
    } imu_sample_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = 8'h00;     // rx_byte
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // axis_x[19:0], axis_y[39:20], axis_z[59:40], temperature_c[76:60], zero fill
    logic [imufd_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [imufd_pkg::KIND_W-1:0]    m_axis_tuser;             // packet_kind

    // bytes still to send, and decoded samples the block still owes us
    logic [7:0]           rx_pending[$];
    imu_sample_t          samples_due[$];

    // shadow of the decoder: position in the frame and the stored frame bytes
    logic [3:0]           frame_pos = 4'd0;
    logic [7:0]           frame_bytes[imufd_pkg::STORE_DEPTH];

    int                   errors = 0;
    int                   bytes_taken = 0;
    int                   samples_seen = 0;
    int                   input_stalls = 0;
    int                   cycle_no = 0;
    logic                 hold_off = 1'b0;
    imu_sample_t          want_sample;

    // random idling on both sides, switched off for one long stretch
    wire jitter_on = !(cycle_no >= 900 && cycle_no < 1300);

    imu_uart_frame_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // division rounded toward minus infinity, d > 0
    function automatic int floor_quot(input int n, input int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // signed little-endian word from stored bytes lo and lo+1
    function automatic int le_word(input int lo);
        logic signed [15:0] w;
        w = {frame_bytes[lo + 1], frame_bytes[lo]};
        return int'(w);
    endfunction

    // raw*16/32768, raw*2000/32768 or raw*180/32768, with 8 fraction bits
    function automatic int axis_value(input imufd_pkg::packet_kind_t k, input int raw);
        case (k)
            imufd_pkg::KIND_ACCEL: return floor_quot(raw, 8);
            imufd_pkg::KIND_RATE:  return floor_quot(raw * 125, 8);
            default:               return floor_quot(raw * 45, 32);
        endcase
    endfunction

    // advance the shadow decoder by one accepted byte, queue a sample on a known frame
    task automatic take_rx_byte(input logic [7:0] b);
        imu_sample_t s;
        int          v;
        logic        known;
        if (frame_pos == 4'd0 || frame_pos > imufd_pkg::LAST_INDEX)
        begin
            // idle: only a header opens a frame
            frame_pos = (b == imufd_pkg::HEADER_BYTE) ? 4'd1 : 4'd0;
        end
        else if (frame_pos < imufd_pkg::LAST_INDEX)
        begin
            // type and data bytes, a 0x55 here is plain data
            frame_bytes[frame_pos - 4'd1] = b;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            // checksum byte closes the frame, its value is not looked at
            frame_pos = 4'd0;
            known = 1'b1;
            s = '0;
            case (frame_bytes[0])
                imufd_pkg::TYPE_ACCEL: s.kind = imufd_pkg::KIND_ACCEL;
                imufd_pkg::TYPE_RATE:  s.kind = imufd_pkg::KIND_RATE;
                imufd_pkg::TYPE_ANGLE: s.kind = imufd_pkg::KIND_ANGLE;
                default:               known = 1'b0;
            endcase
            if (known)
            begin
                v = axis_value(s.kind, le_word(1));
                s.ax = v[imufd_pkg::AXIS_W-1:0];
                v = axis_value(s.kind, le_word(3));
                s.ay = v[imufd_pkg::AXIS_W-1:0];
                v = axis_value(s.kind, le_word(5));
                s.az = v[imufd_pkg::AXIS_W-1:0];
                // raw/340 + 36.25 in 8 fraction bits
                v = floor_quot(le_word(7) * 64 + 788800, 85);
                s.temp = v[imufd_pkg::TEMP_W-1:0];
                samples_due.push_back(s);
            end
        end
    endtask

    task automatic add_frame(input logic [7:0] kind_byte, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] t, input logic [7:0] chk);
        rx_pending.push_back(imufd_pkg::HEADER_BYTE);
        rx_pending.push_back(kind_byte);
        rx_pending.push_back(x[7:0]);
        rx_pending.push_back(x[15:8]);
        rx_pending.push_back(y[7:0]);
        rx_pending.push_back(y[15:8]);
        rx_pending.push_back(z[7:0]);
        rx_pending.push_back(z[15:8]);
        rx_pending.push_back(t[7:0]);
        rx_pending.push_back(t[15:8]);
        rx_pending.push_back(chk);
    endtask

    // mostly random words, now and then one of the range ends
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // any byte that cannot open a frame
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == imufd_pkg::HEADER_BYTE)
            b = 8'h54;
        return b;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: offers the head of the byte queue, runs the shadow decoder on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else
        begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_rx_byte(s_axis_tdata);
                void'(rx_pending.pop_front());
                bytes_taken++;
            end
            // the offered item only changes once it has been taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_pending.size() != 0 &&
                    !(jitter_on && $urandom_range(0, 99) < 8))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_pending[0];
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each sample with the oldest one owed, field by field
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                samples_seen++;
                if (samples_due.size() == 0)
                begin
                    $display("%0t: sample with none expected, kind %0d tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want_sample = samples_due.pop_front();
                    check_field("packet_kind", int'(want_sample.kind), int'(m_axis_tuser));
                    check_field("axis_x", int'($signed(want_sample.ax)),
                                int'($signed(m_axis_tdata[19:0])));
                    check_field("axis_y", int'($signed(want_sample.ay)),
                                int'($signed(m_axis_tdata[39:20])));
                    check_field("axis_z", int'($signed(want_sample.az)),
                                int'($signed(m_axis_tdata[59:40])));
                    check_field("temperature_c", int'($signed(want_sample.temp)),
                                int'($signed(m_axis_tdata[76:60])));
                end
            end
            m_axis_tready <= !hold_off && !(jitter_on && $urandom_range(0, 99) < 8);
        end
    end

    // back-pressure: the receiver stops for a long stretch once traffic is flowing,
    // the sender keeps offering so the decoder holds off the next checksum byte
    initial
    begin
        wait (samples_seen >= 25);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("imu_uart_frame_decoder_test failed");
        $finish;
    end

    initial
    begin
        int r;
        int n;

        // directed: idle noise, range ends of every field, each type, header bytes as data
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'hAA);
        add_frame(imufd_pkg::TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 8'h00);
        add_frame(imufd_pkg::TYPE_RATE,  16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 8'hFF);
        add_frame(imufd_pkg::TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 8'h3C);
        add_frame(imufd_pkg::TYPE_ACCEL, 16'h5555, 16'h0055, 16'h5500, 16'h5555,
                  imufd_pkg::HEADER_BYTE);
        add_frame(8'h50, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'h11);
        add_frame(imufd_pkg::HEADER_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        add_frame(imufd_pkg::TYPE_RATE,  16'hFFF9, 16'h0007, 16'hFFAB, 16'hFEAC, 8'h5A);

        // random: mostly well-formed frames, some unknown types, noise and cut frames
        while (rx_pending.size() < 900)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                n = $urandom_range(0, 2);
                add_frame(n == 0 ? imufd_pkg::TYPE_ACCEL :
                          (n == 1 ? imufd_pkg::TYPE_RATE : imufd_pkg::TYPE_ANGLE),
                          pick_word(), pick_word(), pick_word(), pick_word(),
                          8'($urandom_range(0, 255)));
            end
            else if (r < 88)
            begin
                add_frame(pick_noise() | 8'h80, pick_word(), pick_word(), pick_word(),
                          pick_word(), 8'($urandom_range(0, 255)));
            end
            else if (r < 95)
            begin
                repeat ($urandom_range(1, 4)) rx_pending.push_back(pick_noise());
            end
            else
            begin
                // a header and a few bytes; the next frame's bytes complete it
                rx_pending.push_back(imufd_pkg::HEADER_BYTE);
                repeat ($urandom_range(1, 9))
                    rx_pending.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_pending.size() != 0)
            @(posedge clk);
        while (samples_due.size() != 0)
            @(posedge clk);
        // let any stray output show up
        repeat (20) @(posedge clk);

        $display("sent %0d rx bytes, checked %0d decoded samples", bytes_taken, samples_seen);
        $display("input held off for %0d cycles under receiver back-pressure", input_stalls);
        if (errors == 0)
        begin
            $display("imu_uart_frame_decoder_test passed");
        end
        else
        begin
            $display("imu_uart_frame_decoder_test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/imufd_pkg.sv
rtl/core/imu_uart_frame_decoder.sv
tb/sv/imu_uart_frame_decoder_test.sv
